// ===== src/q2e_pkg.sv =====
package q2e_pkg;

  localparam int QUAT_WIDTH = 16;
  localparam int MFRAC = 28;
  localparam int MW = 40;
  localparam int ZW = 28;
  localparam int CORDIC_STEPS = 20;
  localparam int SQ_STEPS = 32;
  localparam int SQW = 64;
  localparam int ANGLE_W = 16;
  localparam int CODE_W = 2;
  localparam longint NEAR_LO = 64'sd265751101;
  localparam longint NEAR_HI = 64'sd271119811;
  localparam int ANGLE_LIMIT = 23040;
  localparam int RIGHT_ANGLE_Q7 = 11520;

  localparam logic [CODE_W-1:0] CODE_NORMAL = 2'd0;
  localparam logic [CODE_W-1:0] CODE_NEAR_POS = 2'd1;
  localparam logic [CODE_W-1:0] CODE_NEAR_NEG = 2'd2;

  typedef struct packed {
    logic signed [MW-1:0] x;
    logic signed [MW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_t;

  function automatic logic signed [ZW-1:0] atan_deg(input int i);
    logic signed [ZW-1:0] r;
    case (i)
      0: r = 28'sd2949120;
      1: r = 28'sd1740967;
      2: r = 28'sd919879;
      3: r = 28'sd466945;
      4: r = 28'sd234379;
      5: r = 28'sd117304;
      6: r = 28'sd58666;
      7: r = 28'sd29335;
      8: r = 28'sd14668;
      9: r = 28'sd7334;
      10: r = 28'sd3667;
      11: r = 28'sd1833;
      12: r = 28'sd917;
      13: r = 28'sd458;
      14: r = 28'sd229;
      15: r = 28'sd115;
      16: r = 28'sd57;
      17: r = 28'sd29;
      18: r = 28'sd14;
      19: r = 28'sd7;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic cordic_t cordic_pre(input logic signed [MW-1:0] y,
                                         input logic signed [MW-1:0] x);
    cordic_t c;
    c.x = x;
    c.y = y;
    c.z = '0;
    if (x < 0) begin
      if (y >= 0) begin
        c.x = y;
        c.y = -x;
        c.z = 28'sd5898240;
      end else begin
        c.x = -y;
        c.y = x;
        c.z = -28'sd5898240;
      end
    end
    return c;
  endfunction

  function automatic logic signed [ANGLE_W-1:0] to_q7(input logic signed [ZW-1:0] z);
    logic signed [ZW:0] r;
    r = ($signed({z[ZW-1], z}) + (ZW+1)'(256)) >>> 9;
    if (r > (ZW+1)'(ANGLE_LIMIT)) r = (ZW+1)'(ANGLE_LIMIT);
    if (r < -(ZW+1)'(ANGLE_LIMIT)) r = -(ZW+1)'(ANGLE_LIMIT);
    return r[ANGLE_W-1:0];
  endfunction

endpackage

// ===== src/q2e_cordic_cell.sv =====
module q2e_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic                clk,
  input  q2e_pkg::cordic_t    din,
  output q2e_pkg::cordic_t    dout
);

  q2e_pkg::cordic_t nxt;

  always_comb begin
    nxt = din;
    if (din.y > 0) begin
      nxt.x = din.x + (din.y >>> STEP);
      nxt.y = din.y - (din.x >>> STEP);
      nxt.z = din.z + q2e_pkg::atan_deg(STEP);
    end else begin
      nxt.x = din.x - (din.y >>> STEP);
      nxt.y = din.y + (din.x >>> STEP);
      nxt.z = din.z - q2e_pkg::atan_deg(STEP);
    end
  end

  always_ff @(posedge clk) begin
    dout <= nxt;
  end

endmodule

// ===== src/q2e_sqrt_cell.sv =====
module q2e_sqrt_cell #(
  parameter int STEP = 0
) (
  input  logic                         clk,
  input  logic [q2e_pkg::SQW-1:0]      rem_in,
  input  logic [q2e_pkg::SQW-1:0]      root_in,
  output logic [q2e_pkg::SQW-1:0]      rem_out,
  output logic [q2e_pkg::SQW-1:0]      root_out
);

  localparam logic [q2e_pkg::SQW-1:0] BIT = q2e_pkg::SQW'(1) << (62 - 2 * STEP);
  logic [q2e_pkg::SQW-1:0] trial;

  assign trial = root_in + BIT;

  always_ff @(posedge clk) begin
    if (rem_in >= trial) begin
      rem_out  <= rem_in - trial;
      root_out <= (root_in >> 1) + BIT;
    end else begin
      rem_out  <= rem_in;
      root_out <= root_in >> 1;
    end
  end

endmodule

// ===== src/quaternion_to_euler_degrees.sv =====
// Fully pipelined quaternion to Euler angle converter. One quaternion is
// taken on every cycle that start is high (busy is always low), and its
// result appears with a one-cycle strobe on done after a product stage, a
// matrix-term stage, a stage squaring the asin sine term, a 32-cell
// square-root chain for the asin cosine term, a CORDIC set-up stage, a
// 20-cell vectoring CORDIC chain (three chains side by side) and
// one output register. The receiver cannot stall; every strobed beat must be
// taken when shown.
module quaternion_to_euler_degrees #(
  parameter int QUAT_WIDTH = q2e_pkg::QUAT_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [QUAT_WIDTH-1:0]         quat_x,
  input  logic signed [QUAT_WIDTH-1:0]         quat_y,
  input  logic signed [QUAT_WIDTH-1:0]         quat_z,
  input  logic signed [QUAT_WIDTH-1:0]         quat_w,
  output logic                                 done,
  output logic signed [q2e_pkg::ANGLE_W-1:0]   angle_x_deg,
  output logic signed [q2e_pkg::ANGLE_W-1:0]   angle_y_deg,
  output logic signed [q2e_pkg::ANGLE_W-1:0]   angle_z_deg,
  output logic [q2e_pkg::CODE_W-1:0]           branch_code
);

  localparam int MW = q2e_pkg::MW;
  localparam int PW = 2 * QUAT_WIDTH;
  localparam int QFRAC = QUAT_WIDTH - 2;
  localparam int SQ = q2e_pkg::SQ_STEPS;
  localparam int CS = q2e_pkg::CORDIC_STEPS;
  localparam int DLY = SQ + 2 + CS;
  localparam int LAT = 2 + DLY + 1;

  typedef logic signed [MW-1:0] m_t;

  function automatic m_t scale(input logic signed [PW-1:0] p);
    logic signed [PW+MW-1:0] e;
    e = (PW+MW)'(p);
    if (2 * QFRAC >= q2e_pkg::MFRAC) e = e >>> (2 * QFRAC - q2e_pkg::MFRAC);
    else e = e <<< (q2e_pkg::MFRAC - 2 * QFRAC);
    return e[MW-1:0];
  endfunction

  logic [LAT-1:0] vld;
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else vld <= {vld[LAT-2:0], start};
  end
  assign busy = 1'b0;
  assign done = vld[LAT-1];

  // stage 1: products
  m_t x2, y2, z2, xy, xz, yz, wx, wy, wz;
  always_ff @(posedge clk) begin
    x2 <= scale(PW'(quat_x) * PW'(quat_x));
    y2 <= scale(PW'(quat_y) * PW'(quat_y));
    z2 <= scale(PW'(quat_z) * PW'(quat_z));
    xy <= scale(PW'(quat_x) * PW'(quat_y));
    xz <= scale(PW'(quat_x) * PW'(quat_z));
    yz <= scale(PW'(quat_y) * PW'(quat_z));
    wx <= scale(PW'(quat_w) * PW'(quat_x));
    wy <= scale(PW'(quat_w) * PW'(quat_y));
    wz <= scale(PW'(quat_w) * PW'(quat_z));
  end

  // stage 2: matrix terms and branch decision
  localparam m_t ONE = m_t'(1) <<< q2e_pkg::MFRAC;
  m_t m21c;
  logic [q2e_pkg::CODE_W-1:0] code_c;
  assign m21c = 2 * yz - 2 * wx;
  always_comb begin
    if (m21c >= m_t'(q2e_pkg::NEAR_LO) && m21c <= m_t'(q2e_pkg::NEAR_HI))
      code_c = q2e_pkg::CODE_NEAR_POS;
    else if (m21c >= -m_t'(q2e_pkg::NEAR_HI) && m21c <= -m_t'(q2e_pkg::NEAR_LO))
      code_c = q2e_pkg::CODE_NEAR_NEG;
    else
      code_c = q2e_pkg::CODE_NORMAL;
  end

  m_t ya, xa, yb, xb, s;
  logic [q2e_pkg::CODE_W-1:0] code2;
  m_t sc;
  always_comb begin
    sc = -m21c;
    if (sc > ONE) sc = ONE;
    if (sc < -ONE) sc = -ONE;
  end
  logic [q2e_pkg::MFRAC:0] sa;
  logic [2*q2e_pkg::MFRAC+1:0] sa_sq;
  logic [q2e_pkg::SQW-1:0] as2;
  always_ff @(posedge clk) begin
    code2 <= code_c;
    if (code_c == q2e_pkg::CODE_NORMAL) begin
      ya <= 2 * xz + 2 * wy;
      xa <= ONE - 2 * x2 - 2 * y2;
      yb <= 2 * xy + 2 * wz;
      xb <= ONE - 2 * x2 - 2 * z2;
    end else begin
      ya <= '0;
      xa <= '0;
      yb <= 2 * xy - 2 * wz;
      xb <= ONE - 2 * y2 - 2 * z2;
    end
    s <= sc;
    sa <= (q2e_pkg::MFRAC+1)'(sc < 0 ? -sc : sc);
  end

  // stage 3: one minus the squared sine
  assign sa_sq = sa * sa;
  always_ff @(posedge clk) begin
    as2 <= (q2e_pkg::SQW'(1) << (2 * q2e_pkg::MFRAC)) - q2e_pkg::SQW'(sa_sq);
  end

  // square-root chain, with side operands delayed alongside
  logic [q2e_pkg::SQW-1:0] rem [SQ+1];
  logic [q2e_pkg::SQW-1:0] root [SQ+1];
  m_t dya [DLY+1];
  m_t dxa [DLY+1];
  m_t dyb [DLY+1];
  m_t dxb [DLY+1];
  m_t ds [SQ+2];
  logic [q2e_pkg::CODE_W-1:0] dcode [DLY+1];
  assign rem[0] = as2;
  assign root[0] = '0;
  assign dya[0] = ya;
  assign dxa[0] = xa;
  assign dyb[0] = yb;
  assign dxb[0] = xb;
  assign ds[0] = s;
  assign dcode[0] = code2;

  for (genvar i = 0; i < SQ; i++) begin : g_sq
    q2e_sqrt_cell #(.STEP(i)) u_cell (
      .clk(clk), .rem_in(rem[i]), .root_in(root[i]),
      .rem_out(rem[i+1]), .root_out(root[i+1])
    );
  end

  for (genvar i = 0; i < SQ + 1; i++) begin : g_sdly
    always_ff @(posedge clk) begin
      ds[i+1] <= ds[i];
    end
  end

  for (genvar i = 0; i < DLY; i++) begin : g_dly
    always_ff @(posedge clk) begin
      dya[i+1] <= dya[i];
      dxa[i+1] <= dxa[i];
      dyb[i+1] <= dyb[i];
      dxb[i+1] <= dxb[i];
      dcode[i+1] <= dcode[i];
    end
  end

  // cordic set-up
  q2e_pkg::cordic_t cx [CS+1];
  q2e_pkg::cordic_t cy [CS+1];
  q2e_pkg::cordic_t cz [CS+1];
  logic zx0, zy0, zz0;
  logic [CS:0] zxv, zyv, zzv;
  always_ff @(posedge clk) begin
    cx[0] <= q2e_pkg::cordic_pre(ds[SQ+1], m_t'(root[SQ]));
    cy[0] <= q2e_pkg::cordic_pre(dya[SQ+1], dxa[SQ+1]);
    cz[0] <= q2e_pkg::cordic_pre(dyb[SQ+1], dxb[SQ+1]);
    zx0 <= ds[SQ+1] == 0 && root[SQ] == 0;
    zy0 <= dya[SQ+1] == 0 && dxa[SQ+1] == 0;
    zz0 <= dyb[SQ+1] == 0 && dxb[SQ+1] == 0;
  end
  assign zxv[0] = zx0;
  assign zyv[0] = zy0;
  assign zzv[0] = zz0;

  for (genvar i = 0; i < CS; i++) begin : g_cordic
    q2e_cordic_cell #(.STEP(i)) u_cx (.clk(clk), .din(cx[i]), .dout(cx[i+1]));
    q2e_cordic_cell #(.STEP(i)) u_cy (.clk(clk), .din(cy[i]), .dout(cy[i+1]));
    q2e_cordic_cell #(.STEP(i)) u_cz (.clk(clk), .din(cz[i]), .dout(cz[i+1]));
    always_ff @(posedge clk) begin
      zxv[i+1] <= zxv[i];
      zyv[i+1] <= zyv[i];
      zzv[i+1] <= zzv[i];
    end
  end

  // output register
  logic [q2e_pkg::CODE_W-1:0] fc;
  assign fc = dcode[DLY];
  always_ff @(posedge clk) begin
    branch_code <= fc;
    angle_z_deg <= zzv[CS] ? '0 : q2e_pkg::to_q7(cz[CS].z);
    case (fc)
      q2e_pkg::CODE_NEAR_POS: begin
        angle_x_deg <= q2e_pkg::ANGLE_W'(q2e_pkg::RIGHT_ANGLE_Q7);
        angle_y_deg <= '0;
      end
      q2e_pkg::CODE_NEAR_NEG: begin
        angle_x_deg <= -q2e_pkg::ANGLE_W'(q2e_pkg::RIGHT_ANGLE_Q7);
        angle_y_deg <= '0;
      end
      default: begin
        angle_x_deg <= zxv[CS] ? '0 : q2e_pkg::to_q7(cx[CS].z);
        angle_y_deg <= zyv[CS] ? '0 : q2e_pkg::to_q7(cy[CS].z);
      end
    endcase
  end

endmodule
